@@ rtl/rob_pkg.sv @@
// ----------------------------------------------------------------------------
// rob_pkg
// Shared types, codes and the per-bit parse step of the REL object parser.
// ----------------------------------------------------------------------------
package rob_pkg;

    // parse phases
    localparam logic [3:0] PH_FLAG  = 4'd0;
    localparam logic [3:0] PH_ABS   = 4'd1;
    localparam logic [3:0] PH_RTYPE = 4'd2;
    localparam logic [3:0] PH_WORD  = 4'd3;
    localparam logic [3:0] PH_LCODE = 4'd4;
    localparam logic [3:0] PH_ATYPE = 4'd5;
    localparam logic [3:0] PH_ADDR  = 4'd6;
    localparam logic [3:0] PH_NLEN  = 4'd7;
    localparam logic [3:0] PH_NCHAR = 4'd8;

    // result kinds
    localparam logic [2:0] KIND_ABS  = 3'd0;
    localparam logic [2:0] KIND_WORD = 3'd1;
    localparam logic [2:0] KIND_LINK = 3'd2;
    localparam logic [2:0] KIND_NAME = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;
    localparam logic [2:0] KIND_EOF  = 3'd5;

    // address types and special link codes
    localparam logic [1:0] ATYPE_ABS     = 2'd0;
    localparam logic [1:0] ATYPE_DATA    = 2'd2;
    localparam logic [3:0] LINK_LAST_NAME_ONLY = 4'd4;
    localparam logic [3:0] LINK_FIRST_ADDR_NAME = 4'd5;
    localparam logic [3:0] LINK_LAST_ADDR_NAME = 4'd7;
    localparam logic [3:0] LINK_ERROR    = 4'd8;
    localparam logic [3:0] LINK_SET_LOC  = 4'd11;
    localparam logic [3:0] LINK_END_PROG = 4'd14;
    localparam logic [3:0] LINK_END_FILE = 4'd15;

    // name character substitutions
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_A      = 8'h41;

    localparam int FIFO_DEPTH_DEF = 4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic [1:0]  addr_type;
        logic [3:0]  link_code;
        logic [15:0] location;
        logic [2:0]  name_len;
        logic        last;
    } res_t;

    // results of one byte
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r1;
        res_t       r0;
    } ent_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [15:0] shift;
        logic [4:0]  fbits;
        logic [3:0]  code;
        logic [1:0]  atype;
        logic [2:0]  chars;
        logic [15:0] loc;
        logic        halted;
    } st_t;

    typedef struct packed {
        st_t  s;
        logic emit;
        logic flush;
        res_t r;
    } step_t;

    function automatic logic [7:0] rob_subst(input logic [7:0] c);
        logic [7:0] o;
        o = c;
        if (c == CH_DOLLAR) o = CH_S;
        if (c == CH_DOT)    o = CH_UNDER;
        if (c == CH_QUEST)  o = CH_X;
        if (c == CH_AT)     o = CH_A;
        return o;
    endfunction

    // one bit of the stream
    function automatic step_t rob_step(input st_t s, input logic b, input logic [15:0] db);
        step_t       o;
        logic [15:0] a;
        o = '0;
        o.s = s;
        o.r.location = s.loc;
        a = '0;
        case (s.phase)
            PH_ABS:
            begin
                o.s.shift = {8'd0, s.shift[6:0], b};
                o.s.fbits = s.fbits + 5'd1;
                if (o.s.fbits == 5'd8)
                begin
                    o.emit = 1'b1;
                    o.r.kind = KIND_ABS;
                    o.r.value = o.s.shift;
                    o.r.last = 1'b1;
                    o.s.loc = s.loc + 16'd1;
                    o.s.phase = PH_FLAG;
                end
            end
            PH_RTYPE:
            begin
                o.s.atype = {s.atype[0], b};
                o.s.fbits = s.fbits + 5'd1;
                if (o.s.fbits == 5'd2)
                begin
                    o.s.fbits = '0;
                    o.s.shift = '0;
                    if (o.s.atype == ATYPE_ABS)
                    begin
                        o.s.code = '0;
                        o.s.phase = PH_LCODE;
                    end
                    else
                        o.s.phase = PH_WORD;
                end
            end
            PH_WORD:
            begin
                o.s.shift = {s.shift[14:0], b};
                o.s.fbits = s.fbits + 5'd1;
                if (o.s.fbits == 5'd16)
                begin
                    a = {o.s.shift[7:0], o.s.shift[15:8]};
                    if (s.atype == ATYPE_DATA)
                        a = a + db;
                    o.emit = 1'b1;
                    o.r.kind = KIND_WORD;
                    o.r.value = a;
                    o.r.addr_type = s.atype;
                    o.r.last = 1'b1;
                    o.s.loc = s.loc + 16'd2;
                    o.s.phase = PH_FLAG;
                end
            end
            PH_LCODE:
            begin
                o.s.code = {s.code[2:0], b};
                o.s.fbits = s.fbits + 5'd1;
                if (o.s.fbits == 5'd4)
                begin
                    o.s.fbits = '0;
                    o.s.shift = '0;
                    o.s.atype = '0;
                    o.s.chars = '0;
                    if (o.s.code <= LINK_LAST_NAME_ONLY)
                        o.s.phase = PH_NLEN;
                    else if (o.s.code == LINK_ERROR || o.s.code == LINK_END_FILE)
                    begin
                        o.emit = 1'b1;
                        o.r.kind = (o.s.code == LINK_ERROR) ? KIND_ERR : KIND_EOF;
                        o.r.link_code = o.s.code;
                        o.r.last = 1'b1;
                        o.s.halted = 1'b1;
                        o.s.phase = PH_FLAG;
                    end
                    else
                        o.s.phase = PH_ATYPE;
                end
            end
            PH_ATYPE:
            begin
                o.s.atype = {s.atype[0], b};
                o.s.fbits = s.fbits + 5'd1;
                if (o.s.fbits == 5'd2)
                begin
                    o.s.fbits = '0;
                    o.s.shift = '0;
                    o.s.phase = PH_ADDR;
                end
            end
            PH_ADDR:
            begin
                o.s.shift = {s.shift[14:0], b};
                o.s.fbits = s.fbits + 5'd1;
                if (o.s.fbits == 5'd16)
                begin
                    a = {o.s.shift[7:0], o.s.shift[15:8]};
                    o.s.shift = a;
                    o.s.fbits = '0;
                    if (s.code >= LINK_FIRST_ADDR_NAME && s.code <= LINK_LAST_ADDR_NAME)
                    begin
                        o.s.chars = '0;
                        o.s.phase = PH_NLEN;
                    end
                    else
                    begin
                        o.emit = 1'b1;
                        o.r.kind = KIND_LINK;
                        o.r.value = a;
                        o.r.addr_type = s.atype;
                        o.r.link_code = s.code;
                        o.r.last = 1'b1;
                        if (s.code == LINK_SET_LOC)
                            o.s.loc = (s.atype == ATYPE_DATA) ? a + db : a;
                        else if (s.code == LINK_END_PROG)
                        begin
                            o.s.loc = '0;
                            o.s.atype = '0;
                            o.flush = 1'b1;
                        end
                        o.s.phase = PH_FLAG;
                    end
                end
            end
            PH_NLEN:
            begin
                o.s.chars = {s.chars[1:0], b};
                o.s.fbits = s.fbits + 5'd1;
                if (o.s.fbits == 5'd3)
                begin
                    o.emit = 1'b1;
                    o.r.kind = KIND_LINK;
                    o.r.value = s.shift;
                    o.r.addr_type = s.atype;
                    o.r.link_code = s.code;
                    o.r.name_len = o.s.chars;
                    o.r.last = (o.s.chars == 3'd0);
                    o.s.fbits = '0;
                    o.s.shift = '0;
                    o.s.phase = (o.s.chars != 3'd0) ? PH_NCHAR : PH_FLAG;
                end
            end
            PH_NCHAR:
            begin
                o.s.shift = {8'd0, s.shift[6:0], b};
                o.s.fbits = s.fbits + 5'd1;
                if (o.s.fbits == 5'd8)
                begin
                    o.s.chars = s.chars - 3'd1;
                    o.emit = 1'b1;
                    o.r.kind = KIND_NAME;
                    o.r.value = {8'd0, rob_subst(o.s.shift[7:0])};
                    o.r.link_code = s.code;
                    o.r.last = (o.s.chars == 3'd0);
                    o.s.fbits = '0;
                    o.s.shift = '0;
                    if (o.s.chars == 3'd0)
                        o.s.phase = PH_FLAG;
                end
            end
            default:
            begin
                o.s.fbits = '0;
                o.s.shift = '0;
                if (!b)
                    o.s.phase = PH_ABS;
                else
                begin
                    o.s.atype = '0;
                    o.s.phase = PH_RTYPE;
                end
            end
        endcase
        return o;
    endfunction

endpackage

@@ rtl/rob_front.sv @@
// ----------------------------------------------------------------------------
// rob_front
// Takes one byte per transfer, runs its eight bits through the parser up to
// any end-of-program item or halt, and queues the byte's results.
// ----------------------------------------------------------------------------
module rob_front
    import rob_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic [15:0] data_base,
    input  logic        q_full,
    output logic        q_push,
    output ent_t        q_data
);

    st_t   state_reg;
    st_t   state_next;
    ent_t  ent;
    step_t st;
    logic  active;
    logic  take;

    assign in_stall = q_full;
    assign take     = in_valid && !q_full;

    // unrolled bit walk, MSB first
    always_comb
    begin
        state_next = state_reg;
        ent        = '0;
        active     = 1'b1;
        st         = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (active && !state_next.halted)
            begin
                st = rob_step(state_next, data_byte[i], data_base);
                state_next = st.s;
                if (st.emit)
                begin
                    if (ent.cnt == 2'd0)
                        ent.r0 = st.r;
                    else if (ent.cnt == 2'd1)
                        ent.r1 = st.r;
                    if (ent.cnt != 2'd2)
                        ent.cnt = ent.cnt + 2'd1;
                end
                if (st.flush)
                    active = 1'b0;
            end
        end
    end

    assign q_push = take && (ent.cnt != 2'd0);
    assign q_data = ent;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (take)
            state_reg <= state_next;
    end

endmodule

@@ rtl/rob_fifo.sv @@
// ----------------------------------------------------------------------------
// rob_fifo
// Short queue of per-byte result groups between parser and output stage.
// ----------------------------------------------------------------------------
module rob_fifo
    import rob_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  ent_t push_data,
    input  logic pop,
    output ent_t head,
    output logic full,
    output logic empty
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    ent_t          mem [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && empty) |=> (count_reg == CW'(1)))
        else $error("push into empty queue lost");
`endif

endmodule

@@ rtl/rob_back.sv @@
// ----------------------------------------------------------------------------
// rob_back
// Hands out the one or two results of each queued byte, one per transfer.
// ----------------------------------------------------------------------------
module rob_back
    import rob_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ent_t        head,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [15:0] value,
    output logic [1:0]  addr_type,
    output logic [3:0]  link_code,
    output logic [15:0] location,
    output logic [2:0]  name_len,
    output logic        last
);

    logic idx_reg;
    logic xfer;
    res_t cur;

    assign out_valid = !q_empty;
    assign xfer      = out_valid && !out_stall;
    assign cur       = idx_reg ? head.r1 : head.r0;
    assign q_pop     = xfer && (idx_reg || head.cnt != 2'd2);

    assign kind      = cur.kind;
    assign value     = cur.value;
    assign addr_type = cur.addr_type;
    assign link_code = cur.link_code;
    assign location  = cur.location;
    assign name_len  = cur.name_len;
    assign last      = cur.last;

    // second-result select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 1'b0;
        else if (xfer)
            idx_reg <= !q_pop;
    end

endmodule

@@ rtl/rel_object_bitstream_parser_core.sv @@
// ----------------------------------------------------------------------------
// rel_object_bitstream_parser_core
// REL object bit-stream parser: bytes in, absolute/relocated/link results out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_stall is low; its bits, up to any
// end-of-program item, are parsed in the cycle the byte transfers, and
// the results it completes (up to two) go into a FIFO_DEPTH entry queue.
// The output gives one result per cycle while out_stall is low; input
// stalls only when the queue is full. After an error or end-of-file item
// the block keeps taking bytes but gives no results until reset.
// data_base may be written only while no byte is in flight.
module rel_object_bitstream_parser_core
    import rob_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_base_we,
    input  logic [15:0] data_base,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [15:0] value,
    output logic [1:0]  addr_type,
    output logic [3:0]  link_code,
    output logic [15:0] location,
    output logic [2:0]  name_len,
    output logic        last
);

    logic [15:0] data_base_reg;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    ent_t        q_in;
    ent_t        q_head;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_base_reg <= '0;
        else if (data_base_we)
            data_base_reg <= data_base;
    end

    rob_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .data_base (data_base_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    rob_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    rob_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .value     (value),
        .addr_type (addr_type),
        .link_code (link_code),
        .location  (location),
        .name_len  (name_len),
        .last      (last)
    );

endmodule
